// ===== design/lmimb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmimb_pkg
// Types, register indexes and saturation helper shared by the input matrix
// block and its sub-units.
// ----------------------------------------------------------------------------
`default_nettype none

package lmimb_pkg;

	// register indexes on the configuration port
	localparam logic [3:0] REG_INV_XX   = 4'd0;
	localparam logic [3:0] REG_INV_YY   = 4'd1;
	localparam logic [3:0] REG_INV_ZZ   = 4'd2;
	localparam logic [3:0] REG_INV_XY   = 4'd3;
	localparam logic [3:0] REG_INV_XZ   = 4'd4;
	localparam logic [3:0] REG_INV_YZ   = 4'd5;
	localparam logic [3:0] REG_DT_MASS  = 4'd6;
	localparam logic [3:0] REG_HEAD_0   = 4'd7;

	localparam int unsigned CfgIdxW  = 4;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned WideW    = 66;

	typedef struct packed {
		logic        [15:0] reference_heading;
		logic               in_contact;
		logic signed [23:0] lever_x;
		logic signed [23:0] lever_y;
		logic signed [23:0] lever_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] rate_cos;
		logic signed [15:0] rate_sin;
		logic signed [31:0] moment_gain_00;
		logic signed [31:0] moment_gain_01;
		logic signed [31:0] moment_gain_02;
		logic signed [31:0] moment_gain_10;
		logic signed [31:0] moment_gain_11;
		logic signed [31:0] moment_gain_12;
		logic signed [31:0] moment_gain_20;
		logic signed [31:0] moment_gain_21;
		logic signed [31:0] moment_gain_22;
		logic        [30:0] linear_gain;
	} out_item_t;

	// inverse inertia entries as seen by the rotation unit
	typedef struct packed {
		logic signed [31:0] jxx;
		logic signed [31:0] jyy;
		logic signed [31:0] jzz;
		logic signed [31:0] jxy;
		logic signed [31:0] jxz;
		logic signed [31:0] jyz;
	} inertia_t;

	// rotated inertia, symmetric, six distinct entries
	typedef struct packed {
		logic signed [31:0] mxx;
		logic signed [31:0] myy;
		logic signed [31:0] mzz;
		logic signed [31:0] mxy;
		logic signed [31:0] mxz;
		logic signed [31:0] myz;
	} rot_inertia_t;

	// sideband carried alongside the arithmetic
	typedef struct packed {
		logic               contact;
		logic signed [23:0] lx;
		logic signed [23:0] ly;
		logic signed [23:0] lz;
	} side_t;

	// clamp a wide signed value to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
		logic signed [31:0] r;
		if (v > $signed(WideW'(64'sd2147483647))) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < $signed(-WideW'(64'sd2147483648))) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/legged_mpc_input_matrix_block.sv =====
// Throughput: one item per cycle; the nine-stage pipeline (four trig stages,
// three rotation stages, two lever stages) advances as one and holds when a
// result waits at the output.
// Reset: arst_n clears the stage valid bits and all configuration registers.
// ----------------------------------------------------------------------------
// legged_mpc_input_matrix_block
// Heading trig, rotated inverse inertia and per-leg angular input block for
// the discrete rigid-body dynamics of one horizon step.
// ----------------------------------------------------------------------------
`default_nettype none

module legged_mpc_input_matrix_block (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire lmimb_pkg::in_item_t                  in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output lmimb_pkg::out_item_t                      out_data,
	input  wire logic                                 cfg_we,
	input  wire logic [lmimb_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [lmimb_pkg::CfgDataW-1:0]       cfg_wdata
);

	localparam int unsigned Depth = 9;

	lmimb_pkg::inertia_t     inertia_q;
	logic [30:0]             dt_mass_q;
	logic [15:0]             head0_q;
	logic [Depth:1]          valid_q;
	logic                    en;
	lmimb_pkg::side_t        side_s [1:8];
	logic signed [15:0]      hcos_s4, hsin_s4, dcos_s4, dsin_s4;
	logic signed [15:0]      hcos_s [5:9];
	logic signed [15:0]      hsin_s [5:9];
	logic [30:0]             lin_s9;
	lmimb_pkg::rot_inertia_t m_s7;
	logic signed [31:0]      gain_s9 [9];

	// advance the whole pipeline unless a result is held at the output
	assign en       = !valid_q[Depth] || out_ready;
	assign in_ready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= '0;
			dt_mass_q <= '0;
			head0_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lmimb_pkg::REG_INV_XX:  inertia_q.jxx <= cfg_wdata;
				lmimb_pkg::REG_INV_YY:  inertia_q.jyy <= cfg_wdata;
				lmimb_pkg::REG_INV_ZZ:  inertia_q.jzz <= cfg_wdata;
				lmimb_pkg::REG_INV_XY:  inertia_q.jxy <= cfg_wdata;
				lmimb_pkg::REG_INV_XZ:  inertia_q.jxz <= cfg_wdata;
				lmimb_pkg::REG_INV_YZ:  inertia_q.jyz <= cfg_wdata;
				lmimb_pkg::REG_DT_MASS: dt_mass_q     <= cfg_wdata[30:0];
				lmimb_pkg::REG_HEAD_0:  head0_q       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[Depth-1:1], in_valid};
		end
	end

	// sideband and heading trig delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{
				contact: in_data.in_contact,
				lx: in_data.lever_x,
				ly: in_data.lever_y,
				lz: in_data.lever_z
			};
			for (int i = 2; i <= 8; i++) begin
				side_s[i] <= side_s[i-1];
			end
			hcos_s[5] <= hcos_s4;
			hsin_s[5] <= hsin_s4;
			for (int i = 6; i <= 9; i++) begin
				hcos_s[i] <= hcos_s[i-1];
				hsin_s[i] <= hsin_s[i-1];
			end
			lin_s9 <= side_s[8].contact ? dt_mass_q : 31'd0;
		end
	end

	lmimb_sincos u_head_trig (
		.clk   (clk),
		.en    (en),
		.ang   (in_data.reference_heading),
		.cos_o (hcos_s4),
		.sin_o (hsin_s4)
	);

	lmimb_sincos u_delta_trig (
		.clk   (clk),
		.en    (en),
		.ang   (in_data.reference_heading - head0_q),
		.cos_o (dcos_s4),
		.sin_o (dsin_s4)
	);

	lmimb_rotate u_rotate (
		.clk (clk),
		.en  (en),
		.c   (dcos_s4),
		.s   (dsin_s4),
		.j   (inertia_q),
		.m   (m_s7)
	);

	lmimb_lever u_lever (
		.clk  (clk),
		.en   (en),
		.m    (m_s7),
		.side (side_s[7]),
		.gain (gain_s9)
	);

	// present the result
	assign out_valid = valid_q[Depth];
	always_comb begin
		out_data = '{
			rate_cos:       hcos_s[9],
			rate_sin:       hsin_s[9],
			moment_gain_00: gain_s9[0],
			moment_gain_01: gain_s9[1],
			moment_gain_02: gain_s9[2],
			moment_gain_10: gain_s9[3],
			moment_gain_11: gain_s9[4],
			moment_gain_12: gain_s9[5],
			moment_gain_20: gain_s9[6],
			moment_gain_21: gain_s9[7],
			moment_gain_22: gain_s9[8],
			linear_gain:    lin_s9
		};
	end

endmodule

`default_nettype wire

// ===== design/lmimb_sincos.sv =====
// ----------------------------------------------------------------------------
// lmimb_sincos
// Four-stage polynomial sine/cosine of a 16-bit turn angle, Q1.15 results.
// ----------------------------------------------------------------------------
`default_nettype none

module lmimb_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [15:0] ang,
	output logic signed      [15:0] cos_o,
	output logic signed      [15:0] sin_o
);

	logic signed [15:0] res [2];

	for (genvar k = 0; k < 2; k++) begin : g_lane
		logic [15:0] a;
		logic [1:0]  q_in;
		logic [14:0] x_in;
		logic [29:0] sq;
		logic [1:0]  q_s1, q_s2, q_s3;
		logic [14:0] x_s1, x_s2, x_s3;
		logic [14:0] t2_s1, t2_s2;
		logic [14:0] u_s2;
		logic [15:0] w_s3;
		logic [26:0] pu;
		logic [29:0] pw;
		logic [30:0] pr;
		logic [16:0] r;
		logic [15:0] mag;
		logic signed [15:0] res_s4;

		// fold the angle into the first quadrant
		always_comb begin
			a    = ang + ((k == 1) ? 16'd16384 : 16'd0);
			q_in = a[15:14];
			x_in = q_in[0] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
			sq   = 30'(x_in) * 30'(x_in);
			pu   = 27'(t2_s1) * 27'd2320;
			pw   = 30'(u_s2) * 30'(t2_s2);
			pr   = 31'(x_s3) * 31'(w_s3);
			r    = pr[30:14];
			mag  = (r > 17'd32767) ? 16'd32767 : r[15:0];
		end

		// advance the polynomial one term per stage
		always_ff @(posedge clk) begin
			if (en) begin
				q_s1   <= q_in;
				x_s1   <= x_in;
				t2_s1  <= sq[28:14];
				q_s2   <= q_s1;
				x_s2   <= x_s1;
				t2_s2  <= t2_s1;
				u_s2   <= 15'd21024 - 15'(pu[26:14]);
				q_s3   <= q_s2;
				x_s3   <= x_s2;
				w_s3   <= 16'd51472 - pw[29:14];
				res_s4 <= q_s3[1] ? -$signed(mag) : $signed(mag);
			end
		end

		assign res[k] = res_s4;
	end

	assign sin_o = res[0];
	assign cos_o = res[1];

endmodule

`default_nettype wire

// ===== design/lmimb_rotate.sv =====
// ----------------------------------------------------------------------------
// lmimb_rotate
// Three-stage yaw rotation of the symmetric inverse inertia: M = Rz J Rz^T.
// ----------------------------------------------------------------------------
`default_nettype none

module lmimb_rotate (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed        [15:0] c,
	input  wire logic signed        [15:0] s,
	input  wire lmimb_pkg::inertia_t       j,
	output lmimb_pkg::rot_inertia_t        m
);

	localparam int unsigned W = lmimb_pkg::WideW;

	logic signed [31:0] cc_s5, ss_s5, cs_s5;
	logic signed [15:0] c_s5, s_s5;
	logic signed [W-1:0] pa_s6, pb_s6, pc_s6, pd_s6, pe_s6, pf_s6, pg_s6;
	logic signed [W-1:0] ph_s6, pi_s6, pj_s6, pk_s6;
	logic signed [W-1:0] sxx, syy, sxy, sxz, syz;
	lmimb_pkg::rot_inertia_t m_s7;

	// form the trig products, then the inertia products
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s5 <= 32'(c) * 32'(c);
			ss_s5 <= 32'(s) * 32'(s);
			cs_s5 <= 32'(c) * 32'(s);
			c_s5  <= c;
			s_s5  <= s;
			pa_s6 <= W'(cc_s5) * W'(j.jxx);
			pb_s6 <= W'(cs_s5) * W'(j.jxy);
			pc_s6 <= W'(ss_s5) * W'(j.jyy);
			pd_s6 <= W'(ss_s5) * W'(j.jxx);
			pe_s6 <= W'(cc_s5) * W'(j.jyy);
			pf_s6 <= W'(cs_s5) * (W'(j.jxx) - W'(j.jyy));
			pg_s6 <= (W'(cc_s5) - W'(ss_s5)) * W'(j.jxy);
			ph_s6 <= W'(c_s5) * W'(j.jxz);
			pi_s6 <= W'(s_s5) * W'(j.jyz);
			pj_s6 <= W'(s_s5) * W'(j.jxz);
			pk_s6 <= W'(c_s5) * W'(j.jyz);
			m_s7  <= '{
				mxx: lmimb_pkg::sat32(sxx),
				myy: lmimb_pkg::sat32(syy),
				mzz: j.jzz,
				mxy: lmimb_pkg::sat32(sxy),
				mxz: lmimb_pkg::sat32(sxz),
				myz: lmimb_pkg::sat32(syz)
			};
		end
	end

	// sum and round half up
	always_comb begin
		sxx = (pa_s6 - (pb_s6 <<< 1) + pc_s6 + (W'(1) <<< 29)) >>> 30;
		syy = (pd_s6 + (pb_s6 <<< 1) + pe_s6 + (W'(1) <<< 29)) >>> 30;
		sxy = (pf_s6 + pg_s6 + (W'(1) <<< 29)) >>> 30;
		sxz = (ph_s6 - pi_s6 + (W'(1) <<< 14)) >>> 15;
		syz = (pj_s6 + pk_s6 + (W'(1) <<< 14)) >>> 15;
	end

	assign m = m_s7;

endmodule

`default_nettype wire

// ===== design/lmimb_lever.sv =====
// ----------------------------------------------------------------------------
// lmimb_lever
// Two-stage product of the rotated inertia with the lever skew matrix,
// rounded, saturated and forced to zero in swing.
// ----------------------------------------------------------------------------
`default_nettype none

module lmimb_lever (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire lmimb_pkg::rot_inertia_t   m,
	input  wire lmimb_pkg::side_t          side,
	output logic signed             [31:0] gain [9]
);

	localparam int unsigned W = lmimb_pkg::WideW;

	logic signed [31:0] row [3][3];
	logic signed [55:0] p_s8 [3][6];
	logic               contact_s8;
	logic signed [W-1:0] d [3][3];
	logic signed [31:0] g_s9 [9];

	// rows of the symmetric matrix
	always_comb begin
		row[0] = '{m.mxx, m.mxy, m.mxz};
		row[1] = '{m.mxy, m.myy, m.myz};
		row[2] = '{m.mxz, m.myz, m.mzz};
	end

	// take every product of a row entry with a lever component
	always_ff @(posedge clk) begin
		if (en) begin
			contact_s8 <= side.contact;
			for (int i = 0; i < 3; i++) begin
				p_s8[i][0] <= 56'(row[i][1]) * 56'(side.lz);
				p_s8[i][1] <= 56'(row[i][2]) * 56'(side.ly);
				p_s8[i][2] <= 56'(row[i][2]) * 56'(side.lx);
				p_s8[i][3] <= 56'(row[i][0]) * 56'(side.lz);
				p_s8[i][4] <= 56'(row[i][0]) * 56'(side.ly);
				p_s8[i][5] <= 56'(row[i][1]) * 56'(side.lx);
			end
		end
	end

	// difference and round half up from Q44 to Q28
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i][0] = (W'(p_s8[i][0]) - W'(p_s8[i][1]) + (W'(1) <<< 15)) >>> 16;
			d[i][1] = (W'(p_s8[i][2]) - W'(p_s8[i][3]) + (W'(1) <<< 15)) >>> 16;
			d[i][2] = (W'(p_s8[i][4]) - W'(p_s8[i][5]) + (W'(1) <<< 15)) >>> 16;
		end
	end

	// saturate and drop in swing
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					g_s9[3 * i + k] <= contact_s8 ? lmimb_pkg::sat32(d[i][k]) : 32'sd0;
				end
			end
		end
	end

	assign gain = g_s9;

endmodule

`default_nettype wire

// ===== design/lmimb_checker.sv =====
// ----------------------------------------------------------------------------
// lmimb_checker
// Port-level checks for the input matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmimb_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire lmimb_pkg::out_item_t out_data
);

	// hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// input side stalls only behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// trig magnitude is limited to 32767
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.rate_cos != 16'sh8000) && (out_data.rate_sin != 16'sh8000))
		else $error("trig result out of range");

endmodule

bind legged_mpc_input_matrix_block lmimb_checker u_lmimb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Input matrix block testbench
// Drives leg-step transactions through the block under several inertia and
// heading settings, predicts the trig, angular gain and linear gain fields
// and compares every result in order, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lmimb_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	lmimb_pkg::out_item_t out_data;
	logic cfg_we;
	logic [3:0] cfg_index;
	logic [31:0] cfg_wdata;

	legged_mpc_input_matrix_block dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	localparam int IdleLimit = 20000;

	// predictor copy of the registers
	logic signed [31:0] j_xx, j_yy, j_zz, j_xy, j_xz, j_yz;
	logic [30:0] dt_mass;
	logic [15:0] head_start;

	lmimb_pkg::out_item_t gain_queue[$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;
	int n_sent;
	int n_checked;

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic signed [15:0] trig_sin(input logic [15:0] ang);
		logic [1:0] q;
		longint unsigned x, t2, u, w, r;
		q = ang[15:14];
		x = ang[13:0];
		if (q[0])
			x = 16384 - x;
		t2 = (x * x) >> 14;
		u = 21024 - ((2320 * t2) >> 14);
		w = 51472 - ((u * t2) >> 14);
		r = (x * w) >> 14;
		if (r > 32767)
			r = 32767;
		return q[1] ? -$signed(16'(r)) : $signed(16'(r));
	endfunction

	// round half up, then arithmetic shift right
	function automatic longint round_down(input longint v, input int k);
		longint t;
		t = v + (longint'(1) <<< (k - 1));
		return t >>> k;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic lmimb_pkg::out_item_t predict_gains(input lmimb_pkg::in_item_t it);
		lmimb_pkg::out_item_t r;
		logic [15:0] d;
		longint c, s, cc, ss, cs, lx, ly, lz;
		longint m[3][3];
		longint g[9];
		d = it.reference_heading - head_start;
		c = trig_sin(d + 16'd16384);
		s = trig_sin(d);
		cc = c * c;
		ss = s * s;
		cs = c * s;
		lx = it.lever_x;
		ly = it.lever_y;
		lz = it.lever_z;
		m[0][0] = clamp32(round_down(cc * j_xx - 2 * cs * j_xy + ss * j_yy, 30));
		m[1][1] = clamp32(round_down(ss * j_xx + 2 * cs * j_xy + cc * j_yy, 30));
		m[0][1] = clamp32(round_down(cs * (longint'(j_xx) - j_yy) + (cc - ss) * j_xy,
			30));
		m[0][2] = clamp32(round_down(c * j_xz - s * j_yz, 15));
		m[1][2] = clamp32(round_down(s * j_xz + c * j_yz, 15));
		m[2][2] = j_zz;
		m[1][0] = m[0][1];
		m[2][0] = m[0][2];
		m[2][1] = m[1][2];
		for (int i = 0; i < 3; i++) begin
			g[3*i]   = clamp32(round_down(m[i][1] * lz - m[i][2] * ly, 16));
			g[3*i+1] = clamp32(round_down(m[i][2] * lx - m[i][0] * lz, 16));
			g[3*i+2] = clamp32(round_down(m[i][0] * ly - m[i][1] * lx, 16));
			if (!it.in_contact)
				for (int k = 0; k < 3; k++) g[3*i+k] = 0;
		end
		r.rate_cos = trig_sin(it.reference_heading + 16'd16384);
		r.rate_sin = trig_sin(it.reference_heading);
		r.moment_gain_00 = g[0];
		r.moment_gain_01 = g[1];
		r.moment_gain_02 = g[2];
		r.moment_gain_10 = g[3];
		r.moment_gain_11 = g[4];
		r.moment_gain_12 = g[5];
		r.moment_gain_20 = g[6];
		r.moment_gain_21 = g[7];
		r.moment_gain_22 = g[8];
		r.linear_gain = it.in_contact ? dt_mass : 31'd0;
		return r;
	endfunction

	// receiver: stall at random, compare each transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (gain_queue.size() == 0) begin
					$error("result with no prediction waiting");
					errors++;
				end else begin
					lmimb_pkg::out_item_t e;
					e = gain_queue.pop_front();
					n_checked++;
					if (e.rate_cos !== out_data.rate_cos) begin
						$error("rate_cos exp %0d got %0d", e.rate_cos, out_data.rate_cos);
						errors++;
					end
					if (e.rate_sin !== out_data.rate_sin) begin
						$error("rate_sin exp %0d got %0d", e.rate_sin, out_data.rate_sin);
						errors++;
					end
					if (e.moment_gain_00 !== out_data.moment_gain_00) begin
						$error("moment_gain_00 exp %0d got %0d", e.moment_gain_00,
							out_data.moment_gain_00);
						errors++;
					end
					if (e.moment_gain_01 !== out_data.moment_gain_01) begin
						$error("moment_gain_01 exp %0d got %0d", e.moment_gain_01,
							out_data.moment_gain_01);
						errors++;
					end
					if (e.moment_gain_02 !== out_data.moment_gain_02) begin
						$error("moment_gain_02 exp %0d got %0d", e.moment_gain_02,
							out_data.moment_gain_02);
						errors++;
					end
					if (e.moment_gain_10 !== out_data.moment_gain_10) begin
						$error("moment_gain_10 exp %0d got %0d", e.moment_gain_10,
							out_data.moment_gain_10);
						errors++;
					end
					if (e.moment_gain_11 !== out_data.moment_gain_11) begin
						$error("moment_gain_11 exp %0d got %0d", e.moment_gain_11,
							out_data.moment_gain_11);
						errors++;
					end
					if (e.moment_gain_12 !== out_data.moment_gain_12) begin
						$error("moment_gain_12 exp %0d got %0d", e.moment_gain_12,
							out_data.moment_gain_12);
						errors++;
					end
					if (e.moment_gain_20 !== out_data.moment_gain_20) begin
						$error("moment_gain_20 exp %0d got %0d", e.moment_gain_20,
							out_data.moment_gain_20);
						errors++;
					end
					if (e.moment_gain_21 !== out_data.moment_gain_21) begin
						$error("moment_gain_21 exp %0d got %0d", e.moment_gain_21,
							out_data.moment_gain_21);
						errors++;
					end
					if (e.moment_gain_22 !== out_data.moment_gain_22) begin
						$error("moment_gain_22 exp %0d got %0d", e.moment_gain_22,
							out_data.moment_gain_22);
						errors++;
					end
					if (e.linear_gain !== out_data.linear_gain) begin
						$error("linear_gain exp %0d got %0d", e.linear_gain,
							out_data.linear_gain);
						errors++;
					end
				end
			end
		end
	end

	// watchdog: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// raise the write strobe for one register; the caller drops it after the last one
	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			lmimb_pkg::REG_INV_XX:  j_xx = val;
			lmimb_pkg::REG_INV_YY:  j_yy = val;
			lmimb_pkg::REG_INV_ZZ:  j_zz = val;
			lmimb_pkg::REG_INV_XY:  j_xy = val;
			lmimb_pkg::REG_INV_XZ:  j_xz = val;
			lmimb_pkg::REG_INV_YZ:  j_yz = val;
			lmimb_pkg::REG_DT_MASS: dt_mass = val[30:0];
			lmimb_pkg::REG_HEAD_0:  head_start = val[15:0];
			default: ;
		endcase
	endtask

	// send one leg-step, with a random gap first; valid drops at the start of
	// the gap, so a transaction queued straight behind keeps it high
	task automatic send_step(input lmimb_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		gain_queue = {gain_queue, predict_gains(it)};
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (gain_queue.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic signed [23:0] pick_lever();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(131072))) - 24'sd65536;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic lmimb_pkg::in_item_t rand_step();
		lmimb_pkg::in_item_t it;
		it.reference_heading = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 16384)
			: 16'($urandom);
		it.in_contact = ($urandom_range(3) != 0);
		it.lever_x = pick_lever();
		it.lever_y = pick_lever();
		it.lever_z = pick_lever();
		return it;
	endfunction

	task automatic load_inertia(input logic [31:0] xx, yy, zz, xy, xz, yz,
		input logic [31:0] dm, input logic [15:0] h0);
		write_reg(lmimb_pkg::REG_INV_XX, xx);
		write_reg(lmimb_pkg::REG_INV_YY, yy);
		write_reg(lmimb_pkg::REG_INV_ZZ, zz);
		write_reg(lmimb_pkg::REG_INV_XY, xy);
		write_reg(lmimb_pkg::REG_INV_XZ, xz);
		write_reg(lmimb_pkg::REG_INV_YZ, yz);
		write_reg(lmimb_pkg::REG_DT_MASS, dm);
		write_reg(lmimb_pkg::REG_HEAD_0, {16'd0, h0});
		cfg_we <= 1'b0;
	endtask

	// quadrant edges, heading wrap, lever extremes and swing
	task automatic test_directed();
		lmimb_pkg::in_item_t it;
		logic [15:0] heads[8] = '{16'd0, 16'd16384, 16'd32768, 16'd49152,
			16'd65535, 16'd1, 16'd16383, 16'd8192};
		load_inertia(32'h1000_0000, 32'h0800_0000, 32'h0400_0000, 32'h0100_0000,
			32'hFF00_0000, 32'h0080_0000, 32'h7FFF_FFFF, 16'd65000);
		for (int i = 0; i < 8; i++) begin
			it = '{reference_heading: heads[i], in_contact: 1'b1,
				lever_x: 24'sd65536, lever_y: -24'sd32768, lever_z: 24'sd16384};
			send_step(it);
		end
		it = '{16'd100, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
		send_step(it);
		it = '{16'd200, 1'b1, 24'sh800000, 24'sh800000, 24'sh800000};
		send_step(it);
		it = '{16'd300, 1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh123456};
		send_step(it);
		it = '{16'hFFFF, 1'b0, 24'sh000000, 24'sh000000, 24'sh000000};
		send_step(it);
		drain();
		// saturating inertia extremes
		load_inertia(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'd32768);
		for (int i = 0; i < 8; i++) begin
			it = '{heads[i], 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
			send_step(it);
		end
		drain();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 90 == 0) begin
				drain();
				if ($urandom_range(4) == 0)
					load_inertia($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, 16'($urandom));
				else
					load_inertia($urandom_range(32'h2000_0000), $urandom_range(32'h2000_0000),
						$urandom_range(32'h2000_0000), 32'($urandom_range(32'h0200_0000))
						- 32'h0100_0000, 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
						32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
						$urandom_range(32'h7FFF_FFFF), 16'($urandom));
			end
			send_step(rand_step());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		idle_cycles = 0;
		n_sent = 0;
		n_checked = 0;
		j_xx = 0; j_yy = 0; j_zz = 0; j_xy = 0; j_xz = 0; j_yz = 0;
		dt_mass = 0;
		head_start = 0;
		send_idle_pct = 12;
		recv_idle_pct = 72;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(360);
		send_idle_pct = 72;
		recv_idle_pct = 12;
		test_random(360);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(360);
		$display("Sent %0d leg-steps across random inertia and heading settings,",
			n_sent);
		$display("checked %0d results with swing, wrap and saturation cases.", n_checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
